FILE: sv/ddc_pkg.sv
// ----------------------------------------------------------------------------
// ddc_pkg
// Sizes shared by the deadlock detector and its row channel interface.
// ----------------------------------------------------------------------------
package ddc_pkg;

    localparam int MAX_PROCESSES = 8;
    localparam int MAX_RESOURCES = 8;
    localparam int MASK_W        = 8;
    localparam int MASK_IDX_W    = $clog2(MASK_W);
    localparam int CFG_W         = 4;
    localparam int RES_LIM       = (MAX_RESOURCES < MASK_W) ? MAX_RESOURCES : MASK_W;
    localparam int MAX_VERTS     = MAX_PROCESSES + MAX_RESOURCES;
    localparam int PROC_W        = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
    localparam int VERT_W        = $clog2(MAX_VERTS);
    localparam int CUR_W         = $clog2(MAX_VERTS + 1);

    localparam logic [CFG_W-1:0] NUM_RES_RESET = CFG_W'(4);

    typedef logic [MASK_W-1:0] t_mask;

endpackage

FILE: sv/ddc_in_if.sv
// ----------------------------------------------------------------------------
// ddc_in_if
// Process row channel: request and allocation masks plus a last flag.
// ----------------------------------------------------------------------------
interface ddc_in_if;
    import ddc_pkg::*;

    logic  valid;
    logic  ready;
    t_mask request_mask;
    t_mask allocation_mask;
    logic  last;

    modport source (output valid, output request_mask, output allocation_mask,
                    output last, input ready);
    modport sink   (input valid, input request_mask, input allocation_mask,
                    input last, output ready);
endinterface

FILE: sv/ddc_out_if.sv
// ----------------------------------------------------------------------------
// ddc_out_if
// Result channel: one deadlock flag per row set.
// ----------------------------------------------------------------------------
interface ddc_out_if;
    logic valid;
    logic ready;
    logic deadlock;

    modport source (output valid, output deadlock, input ready);
    modport sink   (input valid, input deadlock, output ready);
endinterface

FILE: sv/deadlock_cycle_detector.sv
// ----------------------------------------------------------------------------
// deadlock_cycle_detector
// Cycle search over a resource allocation graph built from process rows.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one process row per word (request mask, allocation mask,
//   last). Rows are taken one per cycle while the block is loading; rows
//   past MAX_PROCESSES are dropped. A word with last set closes the set and
//   starts a depth-first search over processes then resources.
//   The search walks one (vertex, neighbor) pair per cycle through a single
//   edge-test step driven by a small sequencer with an explicit stack. It
//   covers nv = rows + resources vertices (at most 16); the flag word is
//   valid once the search ends. i_in is not ready during the search.
//   o_out carries one word with the deadlock flag per set, held in an output
//   register until taken. Rows of the next set load while it waits; a
//   second result waits in the sequencer until the first is taken.
//   i_cfg_we/i_cfg_wdata write num_resources (reset 4, saturated to the mask
//   width); it is sampled on the last row of each set.
//   Reset (i_rst_n low, synchronous) empties the row set and the output.
// ----------------------------------------------------------------------------
module deadlock_cycle_detector (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [ddc_pkg::CFG_W-1:0] i_cfg_wdata,
    ddc_in_if.sink                i_in,
    ddc_out_if.source             o_out
);
    import ddc_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,
        S_START,
        S_WALK,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_num_resources, n_num_resources;
    logic [CFG_W-1:0]    r_nr, n_nr;
    logic [CNT_W-1:0]    r_row_count, n_row_count;
    logic [MAX_VERTS-1:0] r_visited, n_visited;
    logic [MAX_VERTS-1:0] r_on_path, n_on_path;
    logic [CUR_W-1:0]    r_depth, n_depth;
    logic [CUR_W-1:0]    r_src, n_src;
    logic                r_found, n_found;
    logic                r_out_valid, n_out_valid;
    logic                r_deadlock, n_deadlock;

    t_mask               r_req_rows  [MAX_PROCESSES];
    t_mask               r_hold_rows [MAX_PROCESSES];
    t_mask               n_req_rows  [MAX_PROCESSES];
    t_mask               n_hold_rows [MAX_PROCESSES];
    logic [VERT_W-1:0]   r_path_vertex [MAX_VERTS];
    logic [CUR_W-1:0]    r_path_cursor [MAX_VERTS];
    logic [VERT_W-1:0]   n_path_vertex [MAX_VERTS];
    logic [CUR_W-1:0]    n_path_cursor [MAX_VERTS];

    logic [CFG_W-1:0]    nr_sat;
    logic [CUR_W-1:0]    np;
    logic [CUR_W-1:0]    nv;
    logic [VERT_W-1:0]   top;
    logic [VERT_W-1:0]   v;
    logic [CUR_W-1:0]    v_ext;
    logic [CUR_W-1:0]    c;
    logic [VERT_W-1:0]   c_idx;
    logic [CUR_W-1:0]    c_res;
    logic [CUR_W-1:0]    v_res;
    logic                edge_hit;

    assign nr_sat = (r_num_resources > CFG_W'(RES_LIM)) ? CFG_W'(RES_LIM) : r_num_resources;
    assign np     = CUR_W'(r_row_count);
    assign nv     = np + CUR_W'(r_nr);
    assign top    = VERT_W'(r_depth - CUR_W'(1));
    assign v      = r_path_vertex[top];
    assign v_ext  = CUR_W'(v);
    assign c      = r_path_cursor[top];
    assign c_idx  = c[VERT_W-1:0];
    assign c_res  = c - np;
    assign v_res  = v_ext - np;

    // process -> resource on request, resource -> process on hold
    always_comb begin
        edge_hit = 1'b0;
        if (v_ext < np && c >= np && c_res < CUR_W'(r_nr)) begin
            edge_hit = r_req_rows[v[PROC_W-1:0]][c_res[MASK_IDX_W-1:0]];
        end else if (v_ext >= np && v_res < CUR_W'(r_nr) && c < np) begin
            edge_hit = r_hold_rows[c[PROC_W-1:0]][v_res[MASK_IDX_W-1:0]];
        end
    end

    assign i_in.ready     = (r_state == S_LOAD);
    assign o_out.valid    = r_out_valid;
    assign o_out.deadlock = r_deadlock;

    always_comb begin
        n_state         = r_state;
        n_num_resources = r_num_resources;
        n_nr            = r_nr;
        n_row_count     = r_row_count;
        n_visited       = r_visited;
        n_on_path       = r_on_path;
        n_depth         = r_depth;
        n_src           = r_src;
        n_found         = r_found;
        n_out_valid     = r_out_valid;
        n_deadlock      = r_deadlock;
        n_req_rows      = r_req_rows;
        n_hold_rows     = r_hold_rows;
        n_path_vertex   = r_path_vertex;
        n_path_cursor   = r_path_cursor;

        if (i_cfg_we) begin
            n_num_resources = i_cfg_wdata;
        end
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                if (i_in.valid) begin
                    if (r_row_count < CNT_W'(MAX_PROCESSES)) begin
                        n_req_rows[r_row_count[PROC_W-1:0]]  = i_in.request_mask;
                        n_hold_rows[r_row_count[PROC_W-1:0]] = i_in.allocation_mask;
                        n_row_count = r_row_count + CNT_W'(1);
                    end
                    if (i_in.last) begin
                        n_nr      = nr_sat;
                        n_src     = '0;
                        n_visited = '0;
                        n_on_path = '0;
                        n_depth   = '0;
                        n_state   = S_START;
                    end
                end
            end
            S_START: begin
                if (r_src >= nv) begin
                    n_found = 1'b0;
                    n_state = S_FINISH;
                end else if (r_visited[r_src[VERT_W-1:0]]) begin
                    n_src = r_src + CUR_W'(1);
                end else begin
                    n_visited[r_src[VERT_W-1:0]] = 1'b1;
                    n_on_path[r_src[VERT_W-1:0]] = 1'b1;
                    n_path_vertex[0] = r_src[VERT_W-1:0];
                    n_path_cursor[0] = '0;
                    n_depth          = CUR_W'(1);
                    n_state          = S_WALK;
                end
            end
            S_WALK: begin
                if (c >= nv) begin
                    // all neighbors tried: pop
                    n_on_path[v] = 1'b0;
                    n_depth      = r_depth - CUR_W'(1);
                    if (r_depth == CUR_W'(1)) begin
                        n_src   = r_src + CUR_W'(1);
                        n_state = S_START;
                    end
                end else begin
                    n_path_cursor[top] = c + CUR_W'(1);
                    if (edge_hit) begin
                        if (r_on_path[c_idx]) begin
                            // back edge closes a cycle
                            n_found = 1'b1;
                            n_state = S_FINISH;
                        end else if (!r_visited[c_idx] && r_depth < CUR_W'(MAX_VERTS)) begin
                            n_visited[c_idx] = 1'b1;
                            n_on_path[c_idx] = 1'b1;
                            n_path_vertex[r_depth[VERT_W-1:0]] = c_idx;
                            n_path_cursor[r_depth[VERT_W-1:0]] = '0;
                            n_depth = r_depth + CUR_W'(1);
                        end
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_deadlock  = r_found;
                    n_row_count = '0;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_LOAD;
            r_num_resources <= NUM_RES_RESET;
            r_nr            <= '0;
            r_row_count     <= '0;
            r_visited       <= '0;
            r_on_path       <= '0;
            r_depth         <= '0;
            r_src           <= '0;
            r_found         <= 1'b0;
            r_out_valid     <= 1'b0;
            r_deadlock      <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_num_resources <= n_num_resources;
            r_nr            <= n_nr;
            r_row_count     <= n_row_count;
            r_visited       <= n_visited;
            r_on_path       <= n_on_path;
            r_depth         <= n_depth;
            r_src           <= n_src;
            r_found         <= n_found;
            r_out_valid     <= n_out_valid;
            r_deadlock      <= n_deadlock;
        end
    end

    // row store and search stack carry no reset
    always_ff @(posedge i_clk) begin
        r_req_rows    <= n_req_rows;
        r_hold_rows   <= n_hold_rows;
        r_path_vertex <= n_path_vertex;
        r_path_cursor <= n_path_cursor;
    end

endmodule
